/* src/hlwa_pkg.sv */
package hlwa_pkg;

  localparam int MAX_BLOCKS_DEF  = 64;
  localparam int MAX_HOLES_DEF   = 65;
  localparam int OFFSET_BITS_DEF = 16;

  localparam int SIZE_W     = 16;
  localparam int BYTE_W     = 19;
  localparam int WB_W       = 4;
  localparam int DIVD_W     = 20;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_TDATA_W = 40;
  localparam int OUT_TDATA_W = 40;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_BYTES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEMORY_WORDS = 2'd2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;
  localparam logic FIT_BEST  = 1'b0;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_HOLE_RD, OP_ALLOC_EVAL, OP_ALLOC_COMMIT, OP_DN_RD, OP_DN_WR,
    OP_HC_DEC, OP_BLK_RD, OP_FREE_EVAL, OP_HOLE_WALK, OP_BLK_RDLAST, OP_FREE_COMMIT,
    OP_UP_RD, OP_UP_WR, OP_UP_FIN, OP_FINISH
  } dp_op_t;

  typedef enum logic [2:0] {
    RES_NOFIT, RES_FULL, RES_NOTFOUND, RES_ALLOC, RES_FREE
  } res_kind_t;

  typedef struct packed {
    dp_op_t    op;
    res_kind_t res;
  } dp_cmd_t;

  typedef struct packed {
    logic init_busy;
    logic is_free;
    logic div_done;
    logic bad_size;
    logic blk_full;
    logic found;
    logic exact;
    logic more_holes;
    logic more_blocks;
    logic blk_hit;
    logic hole_le;
    logic mprev;
    logic mnext;
    logic holes_full;
    logic dn_more;
    logic up_more;
    logic out_free;
  } dp_stat_t;

endpackage

/* src/hole_list_word_allocator_unit.sv */
// one item at a time: the divide step makes 20 quotient bits, one per cycle, then signals done,
// then a read and an evaluate or write step per table entry, as each table has a single registered read port
// allocate: divide, size check, hole scan, commit, and a shift down of later holes on an exact fit
// free: divide, block search, hole walk, commit, and a shift of holes on an add or a double merge
// rst is synchronous: best fit, 4-byte words, 65535-word region, one hole, no blocks;
// the first hole entry is written the cycle after reset or a region-size write
module hole_list_word_allocator_unit import hlwa_pkg::*; #(
  parameter int MAX_BLOCKS  = MAX_BLOCKS_DEF,
  parameter int MAX_HOLES   = MAX_HOLES_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // input beats
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // size_bytes[18:0], byte_address[37:19], zero pad
  input  logic                   s_tuser,   // cmd: 0 allocate, 1 free
  // result beats
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // status[1:0], block_offset[20:2], block_words[36:21]
  // register writes: 0 fit_mode, 1 word_bytes, 2 memory_words
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_addr,
  input  logic [SIZE_W-1:0]      cfg_wdata
);

  dp_cmd_t             cmd;
  dp_stat_t            stat;
  logic                div_start;
  logic                div_done;
  logic [DIVD_W-1:0]   div_dividend;
  logic [DIVD_W-1:0]   div_quot;
  logic [WB_W-1:0]     div_divisor;
  logic [STATUS_W-1:0] out_status;
  logic [BYTE_W-1:0]   out_offset;
  logic [SIZE_W-1:0]   out_words;

  // sequencer for scans, shifts and merges
  hlwa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // byte-to-word conversion, shared by allocate rounding and free lookup
  hlwa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quot     (div_quot),
    .done     (div_done)
  );

  // hole and block tables, config registers, result register
  hlwa_datapath #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .MAX_HOLES   (MAX_HOLES),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_cmd       (s_tuser),
    .in_size      (s_tdata[BYTE_W-1:0]),
    .in_addr      (s_tdata[2*BYTE_W-1:BYTE_W]),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_quot     (div_quot),
    .div_done     (div_done),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .out_status   (out_status),
    .out_offset   (out_offset),
    .out_words    (out_words)
  );

  assign m_tdata = {{(OUT_TDATA_W - STATUS_W - BYTE_W - SIZE_W){1'b0}},
                    out_words, out_offset, out_status};

  // one item in flight: an accepted beat closes the input until it is done
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted twice in a row");

  // a region-size write must hold off items while the first hole is set up
  assert property (@(posedge clk) disable iff (rst)
    (cfg_we && (cfg_addr == REG_MEMORY_WORDS)) |=> !s_tready)
    else $error("input open during table reinit");

  // results leave only through the result register after a finish
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.op == OP_FINISH))
    else $error("result appeared without a finish");

endmodule

/* src/hlwa_div.sv */
module hlwa_div import hlwa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [WB_W-1:0]   divisor,
  output logic [DIVD_W-1:0] quot,
  output logic              done
);

  localparam int CNT_W = $clog2(DIVD_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [WB_W-1:0]  rem;
  logic [WB_W-1:0]  dvs;
  logic [WB_W:0]    trial;

  // one quotient bit per cycle, restoring
  assign trial = {rem, quot[DIVD_W-1]};
  assign done  = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DIVD_W - 1);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= dividend;
      dvs  <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem  <= WB_W'(trial - {1'b0, dvs});
        quot <= {quot[DIVD_W-2:0], 1'b1};
      end else begin
        rem  <= trial[WB_W-1:0];
        quot <= {quot[DIVD_W-2:0], 1'b0};
      end
    end
  end

endmodule

/* src/hlwa_datapath.sv */
module hlwa_datapath import hlwa_pkg::*; #(
  parameter int MAX_BLOCKS  = MAX_BLOCKS_DEF,
  parameter int MAX_HOLES   = MAX_HOLES_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  input  logic                 in_cmd,
  input  logic [BYTE_W-1:0]    in_size,
  input  logic [BYTE_W-1:0]    in_addr,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [SIZE_W-1:0]    cfg_wdata,
  output logic                 div_start,
  output logic [DIVD_W-1:0]    div_dividend,
  output logic [WB_W-1:0]      div_divisor,
  input  logic [DIVD_W-1:0]    div_quot,
  input  logic                 div_done,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [STATUS_W-1:0]  out_status,
  output logic [BYTE_W-1:0]    out_offset,
  output logic [SIZE_W-1:0]    out_words
);

  localparam int OW   = OFFSET_BITS;
  localparam int CW   = ((OW > BYTE_W) ? OW : BYTE_W) + 2;
  localparam int HAW  = $clog2(MAX_HOLES);
  localparam int BAW  = $clog2(MAX_BLOCKS);
  localparam int HCW  = $clog2(MAX_HOLES + 1);
  localparam int BCW  = $clog2(MAX_BLOCKS + 1);
  localparam int IW   = (HCW > BCW) ? HCW : BCW;
  localparam logic [31:0] OMASK = (32'd1 << OW) - 32'd1;

  // configuration
  logic              fit_mode;
  logic [WB_W-1:0]   word_bytes;
  logic [SIZE_W-1:0] memory_words;
  logic              init_busy;
  logic [WB_W-1:0]   wbe;

  // table state
  logic [HCW-1:0] hc;
  logic [BCW-1:0] bc;
  logic [OW-1:0]     hole_off  [MAX_HOLES];
  logic [SIZE_W-1:0] hole_size [MAX_HOLES];
  logic [OW-1:0]     blk_off   [MAX_BLOCKS];
  logic [SIZE_W-1:0] blk_size  [MAX_BLOCKS];
  logic [OW-1:0]     hrd_off;
  logic [SIZE_W-1:0] hrd_size;
  logic [OW-1:0]     brd_off;
  logic [SIZE_W-1:0] brd_size;

  // per-item working registers
  logic              cmd_q;
  logic [BYTE_W-1:0] size_q;
  logic [IW-1:0]     idx;
  logic [IW-1:0]     j;
  logic [HAW-1:0]    pick;
  logic [OW-1:0]     pick_off;
  logic [SIZE_W-1:0] pick_size;
  logic              found;
  logic [BAW-1:0]    b;
  logic [OW-1:0]     boff;
  logic [SIZE_W-1:0] bsize;
  logic [OW-1:0]     prev_off;
  logic [SIZE_W-1:0] prev_size;
  logic [OW-1:0]     next_off;
  logic [SIZE_W-1:0] next_size;
  logic              next_valid;

  logic [SIZE_W-1:0] words;
  logic [CW-1:0]     word_ix;
  logic [CW-1:0]     bend;
  logic [CW-1:0]     prev_end;
  logic [CW-1:0]     new_off_w;
  logic [CW-1:0]     byte_off_w;
  logic [IW-1:0]     idx_m1;
  logic [IW-1:0]     idx_p1;
  logic [IW-1:0]     j_m1;
  logic              better;

  // memory ports
  logic              hre, hwe, bre, bwe;
  logic [HAW-1:0]    hraddr, hwaddr;
  logic [BAW-1:0]    braddr, bwaddr;
  logic [OW-1:0]     hwoff, bwoff;
  logic [SIZE_W-1:0] hwsize, bwsize;

  always_comb begin
    if (word_bytes == '0) begin
      wbe = WB_W'(1);
    end else if (word_bytes > WB_W'(8)) begin
      wbe = WB_W'(8);
    end else begin
      wbe = word_bytes;
    end
  end

  assign words      = div_quot[SIZE_W-1:0];
  assign word_ix    = CW'(div_quot);
  assign bend       = CW'(boff) + CW'(bsize);
  assign prev_end   = CW'(prev_off) + CW'(prev_size);
  assign new_off_w  = CW'(pick_off) + CW'(words);
  assign byte_off_w = CW'(pick_off) * CW'(wbe);
  assign idx_m1     = idx - IW'(1);
  assign idx_p1     = idx + IW'(1);
  assign j_m1       = j - IW'(1);
  assign better     = !found ||
                      ((fit_mode == FIT_BEST) && (hrd_size < pick_size)) ||
                      ((fit_mode != FIT_BEST) && (hrd_size > pick_size));

  assign div_start    = (cmd.op == OP_LOAD);
  assign div_divisor  = wbe;
  assign div_dividend = (in_cmd == CMD_FREE) ? DIVD_W'(in_addr)
                        : DIVD_W'(in_size) + DIVD_W'(wbe) - DIVD_W'(1);

  always_comb begin
    stat.init_busy   = init_busy;
    stat.is_free     = (cmd_q == CMD_FREE);
    stat.div_done    = div_done;
    stat.bad_size    = (size_q == '0) ||
                       (DIVD_W'(size_q) > DIVD_W'(memory_words) * DIVD_W'(wbe));
    stat.blk_full    = (BCW'(bc) >= BCW'(MAX_BLOCKS));
    stat.found       = found;
    stat.exact       = (pick_size == words);
    stat.more_holes  = (IW'(idx) < IW'(hc));
    stat.more_blocks = (IW'(idx) < IW'(bc));
    stat.blk_hit     = (word_ix >= CW'(brd_off)) &&
                       (word_ix < CW'(brd_off) + CW'(brd_size));
    stat.hole_le     = (hrd_off <= boff);
    stat.mprev       = (idx != '0) && (prev_end == CW'(boff));
    stat.mnext       = next_valid && (CW'(next_off) == bend);
    stat.holes_full  = (HCW'(hc) >= HCW'(MAX_HOLES));
    stat.dn_more     = (idx_p1 < IW'(hc));
    stat.up_more     = (j > idx);
    stat.out_free    = !out_valid || out_ready;
  end

  // table port selection
  always_comb begin
    hre = 1'b0; hraddr = '0;
    bre = 1'b0; braddr = '0;
    hwe = 1'b0; hwaddr = '0; hwoff = '0; hwsize = '0;
    bwe = 1'b0; bwaddr = '0; bwoff = '0; bwsize = '0;
    if (init_busy) begin
      hwe    = 1'b1;
      hwsize = memory_words & OMASK[SIZE_W-1:0];
    end else begin
      case (cmd.op)
        OP_HOLE_RD: begin
          hre = 1'b1; hraddr = idx[HAW-1:0];
        end
        OP_DN_RD: begin
          hre = 1'b1; hraddr = idx_p1[HAW-1:0];
        end
        OP_UP_RD: begin
          hre = 1'b1; hraddr = j_m1[HAW-1:0];
        end
        OP_BLK_RD: begin
          bre = 1'b1; braddr = idx[BAW-1:0];
        end
        OP_BLK_RDLAST: begin
          bre = 1'b1; braddr = BAW'(bc - BCW'(1));
        end
        OP_DN_WR: begin
          hwe = 1'b1; hwaddr = idx[HAW-1:0]; hwoff = hrd_off; hwsize = hrd_size;
        end
        OP_UP_WR: begin
          hwe = 1'b1; hwaddr = j[HAW-1:0]; hwoff = hrd_off; hwsize = hrd_size;
        end
        OP_UP_FIN: begin
          hwe = 1'b1; hwaddr = idx[HAW-1:0]; hwoff = boff; hwsize = bsize;
        end
        OP_ALLOC_COMMIT: begin
          bwe    = 1'b1;
          bwaddr = bc[BAW-1:0];
          bwoff  = pick_off;
          bwsize = words;
          // partial fit shrinks the hole from its low end
          hwe    = !stat.exact;
          hwaddr = pick;
          hwoff  = new_off_w[OW-1:0];
          hwsize = pick_size - words;
        end
        OP_FREE_COMMIT: begin
          bwe    = 1'b1;
          bwaddr = b;
          bwoff  = brd_off;
          bwsize = brd_size;
          if (stat.mprev && stat.mnext) begin
            hwe = 1'b1; hwaddr = idx_m1[HAW-1:0]; hwoff = prev_off;
            hwsize = prev_size + bsize + next_size;
          end else if (stat.mprev) begin
            hwe = 1'b1; hwaddr = idx_m1[HAW-1:0]; hwoff = prev_off;
            hwsize = prev_size + bsize;
          end else if (stat.mnext) begin
            hwe = 1'b1; hwaddr = idx[HAW-1:0]; hwoff = boff;
            hwsize = next_size + bsize;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (hwe) begin
      hole_off[hwaddr]  <= hwoff;
      hole_size[hwaddr] <= hwsize;
    end
    if (hre) begin
      hrd_off  <= hole_off[hraddr];
      hrd_size <= hole_size[hraddr];
    end
  end

  always_ff @(posedge clk) begin
    if (bwe) begin
      blk_off[bwaddr]  <= bwoff;
      blk_size[bwaddr] <= bwsize;
    end
    if (bre) begin
      brd_off  <= blk_off[braddr];
      brd_size <= blk_size[braddr];
    end
  end

  // configuration and table counts
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode     <= FIT_BEST;
      word_bytes   <= WB_W'(4);
      memory_words <= '1;
      init_busy    <= 1'b1;
      hc           <= HCW'(1);
      bc           <= '0;
    end else begin
      if (init_busy) begin
        init_busy <= 1'b0;
      end
      case (cmd.op)
        OP_ALLOC_COMMIT: bc <= bc + BCW'(1);
        OP_FREE_COMMIT:  bc <= bc - BCW'(1);
        OP_HC_DEC:       hc <= hc - HCW'(1);
        OP_UP_FIN:       hc <= hc + HCW'(1);
        default: begin
        end
      endcase
      if (cfg_we) begin
        case (cfg_addr)
          REG_FIT_MODE:   fit_mode <= cfg_wdata[0];
          REG_WORD_BYTES: word_bytes <= cfg_wdata[WB_W-1:0];
          REG_MEMORY_WORDS: begin
            memory_words <= cfg_wdata;
            init_busy    <= 1'b1;
            bc           <= '0;
            hc           <= (cfg_wdata != '0) ? HCW'(1) : '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      found      <= 1'b0;
      next_valid <= 1'b0;
      idx        <= '0;
      j          <= '0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          idx        <= '0;
          found      <= 1'b0;
          next_valid <= 1'b0;
        end
        OP_ALLOC_EVAL: begin
          if ((hrd_size >= words) && better) begin
            pick      <= idx[HAW-1:0];
            pick_off  <= hrd_off;
            pick_size <= hrd_size;
            found     <= 1'b1;
          end
          idx <= idx_p1;
        end
        OP_ALLOC_COMMIT: idx <= IW'(pick);
        OP_DN_WR:        idx <= idx_p1;
        OP_FREE_EVAL: begin
          if (stat.blk_hit) begin
            idx <= '0;
          end else begin
            idx <= idx_p1;
          end
        end
        OP_HOLE_WALK: begin
          if (stat.hole_le) begin
            idx <= idx_p1;
          end else begin
            next_valid <= 1'b1;
          end
        end
        OP_FREE_COMMIT: j <= IW'(hc);
        OP_UP_WR:       j <= j_m1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      cmd_q  <= in_cmd;
      size_q <= in_size;
    end
    if ((cmd.op == OP_FREE_EVAL) && stat.blk_hit) begin
      b     <= idx[BAW-1:0];
      boff  <= brd_off;
      bsize <= brd_size;
    end
    if (cmd.op == OP_HOLE_WALK) begin
      if (stat.hole_le) begin
        prev_off  <= hrd_off;
        prev_size <= hrd_size;
      end else begin
        next_off  <= hrd_off;
        next_size <= hrd_size;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_FINISH) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_FINISH) begin
      out_offset <= '0;
      out_words  <= '0;
      case (cmd.res)
        RES_ALLOC: begin
          out_status <= ST_OK;
          out_offset <= byte_off_w[BYTE_W-1:0];
          out_words  <= words;
        end
        RES_FREE: begin
          out_status <= ST_OK;
          out_words  <= bsize;
        end
        RES_FULL:     out_status <= ST_FULL;
        RES_NOTFOUND: out_status <= ST_NOTFOUND;
        default:      out_status <= ST_NOFIT;
      endcase
    end
  end

endmodule

/* src/hlwa_ctrl.sv */
module hlwa_ctrl import hlwa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_DIV   = 17'h00002,
    S_ACHK  = 17'h00004,
    S_ARD   = 17'h00008,
    S_AEV   = 17'h00010,
    S_APICK = 17'h00020,
    S_DN_RD = 17'h00040,
    S_DN_WR = 17'h00080,
    S_FRD   = 17'h00100,
    S_FEV   = 17'h00200,
    S_HRD   = 17'h00400,
    S_HEV   = 17'h00800,
    S_FDEC  = 17'h01000,
    S_FMOVE = 17'h02000,
    S_UP_RD = 17'h04000,
    S_UP_WR = 17'h08000,
    S_DONE  = 17'h10000
  } state_t;

  state_t    state, state_next;
  res_kind_t res, res_next;

  assign in_ready = (state == S_IDLE) && !stat.init_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res   <= RES_NOFIT;
    end else begin
      state <= state_next;
      res   <= res_next;
    end
  end

  always_comb begin
    state_next = state;
    res_next   = res;
    cmd.op     = OP_NONE;
    cmd.res    = res;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.op     = OP_LOAD;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_next = stat.is_free ? S_FRD : S_ACHK;
        end
      end
      S_ACHK: begin
        if (stat.bad_size) begin
          res_next = RES_NOFIT; state_next = S_DONE;
        end else if (stat.blk_full) begin
          res_next = RES_FULL; state_next = S_DONE;
        end else begin
          state_next = S_ARD;
        end
      end
      S_ARD: begin
        if (stat.more_holes) begin
          cmd.op = OP_HOLE_RD; state_next = S_AEV;
        end else begin
          state_next = S_APICK;
        end
      end
      S_AEV: begin
        cmd.op = OP_ALLOC_EVAL; state_next = S_ARD;
      end
      S_APICK: begin
        if (!stat.found) begin
          res_next = RES_NOFIT; state_next = S_DONE;
        end else begin
          cmd.op     = OP_ALLOC_COMMIT;
          res_next   = RES_ALLOC;
          state_next = stat.exact ? S_DN_RD : S_DONE;
        end
      end
      S_DN_RD: begin
        if (stat.dn_more) begin
          cmd.op = OP_DN_RD; state_next = S_DN_WR;
        end else begin
          cmd.op = OP_HC_DEC; state_next = S_DONE;
        end
      end
      S_DN_WR: begin
        cmd.op = OP_DN_WR; state_next = S_DN_RD;
      end
      S_FRD: begin
        if (stat.more_blocks) begin
          cmd.op = OP_BLK_RD; state_next = S_FEV;
        end else begin
          res_next = RES_NOTFOUND; state_next = S_DONE;
        end
      end
      S_FEV: begin
        cmd.op     = OP_FREE_EVAL;
        state_next = stat.blk_hit ? S_HRD : S_FRD;
      end
      S_HRD: begin
        if (stat.more_holes) begin
          cmd.op = OP_HOLE_RD; state_next = S_HEV;
        end else begin
          state_next = S_FDEC;
        end
      end
      S_HEV: begin
        cmd.op     = OP_HOLE_WALK;
        state_next = stat.hole_le ? S_HRD : S_FDEC;
      end
      S_FDEC: begin
        if (!stat.mprev && !stat.mnext && stat.holes_full) begin
          res_next = RES_FULL; state_next = S_DONE;
        end else begin
          cmd.op = OP_BLK_RDLAST; state_next = S_FMOVE;
        end
      end
      S_FMOVE: begin
        cmd.op   = OP_FREE_COMMIT;
        res_next = RES_FREE;
        if (stat.mprev && stat.mnext) begin
          state_next = S_DN_RD;
        end else if (stat.mprev || stat.mnext) begin
          state_next = S_DONE;
        end else begin
          state_next = S_UP_RD;
        end
      end
      S_UP_RD: begin
        if (stat.up_more) begin
          cmd.op = OP_UP_RD; state_next = S_UP_WR;
        end else begin
          cmd.op = OP_UP_FIN; state_next = S_DONE;
        end
      end
      S_UP_WR: begin
        cmd.op = OP_UP_WR; state_next = S_UP_RD;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.op = OP_FINISH; state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* dv/hlwa_checker.sv */
`timescale 1ns / 1ps
module hlwa_checker import hlwa_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tuser,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_addr,
  input  logic [SIZE_W-1:0]      cfg_wdata,
  output int                     fail_count,
  output int                     pending
);

  localparam int NB = MAX_BLOCKS_DEF;
  localparam int NH = MAX_HOLES_DEF;

  // lowest bits last: status sits at the bottom of the result beat
  typedef struct packed {
    logic [SIZE_W-1:0]   words;
    logic [BYTE_W-1:0]   offset;
    logic [STATUS_W-1:0] status;
  } alloc_result_t;

  logic              mode_q;
  logic [WB_W-1:0]   wbytes_q;
  logic [SIZE_W-1:0] region_q;
  int unsigned hole_off [NH+1];
  int unsigned hole_len [NH+1];
  int unsigned hole_n;
  int unsigned blk_off [NB];
  int unsigned blk_len [NB];
  int unsigned blk_n;
  alloc_result_t expected_results[$];

  function automatic int unsigned eff_wb();
    if (wbytes_q == 0) return 1;
    if (wbytes_q > 8) return 8;
    return wbytes_q;
  endfunction

  task automatic clear_heap();
    blk_n = 0;
    hole_n = (region_q == 0) ? 0 : 1;
    hole_off[0] = 0;
    hole_len[0] = region_q;
  endtask

  function automatic alloc_result_t mk(int unsigned st, int unsigned o, int unsigned w);
    alloc_result_t r;
    r.status = st[1:0];
    r.offset = o[BYTE_W-1:0];
    r.words  = w[SIZE_W-1:0];
    return r;
  endfunction

  task automatic predict_alloc(input int unsigned sz, output alloc_result_t r);
    int unsigned wb, words, pick, o;
    bit found;
    wb = eff_wb();
    found = 0;
    pick = 0;
    if (sz == 0 || sz > region_q * wb) begin
      r = mk(ST_NOFIT, 0, 0);
      return;
    end
    if (blk_n >= NB) begin
      r = mk(ST_FULL, 0, 0);
      return;
    end
    words = (sz + wb - 1) / wb;
    for (int i = 0; i < hole_n; i++) begin
      if (hole_len[i] < words) continue;
      if (!found || (mode_q == FIT_BEST && hole_len[i] < hole_len[pick]) ||
          (mode_q != FIT_BEST && hole_len[i] > hole_len[pick])) begin
        pick = i;
        found = 1;
      end
    end
    if (!found) begin
      r = mk(ST_NOFIT, 0, 0);
      return;
    end
    o = hole_off[pick];
    blk_off[blk_n] = o;
    blk_len[blk_n] = words;
    blk_n++;
    if (hole_len[pick] == words) begin
      for (int i = pick; i + 1 < hole_n; i++) begin
        hole_off[i] = hole_off[i+1];
        hole_len[i] = hole_len[i+1];
      end
      hole_n--;
    end else begin
      hole_off[pick] = (o + words) & 16'hFFFF;
      hole_len[pick] -= words;
    end
    r = mk(ST_OK, o * wb, words);
  endtask

  task automatic predict_free(input int unsigned addr, output alloc_result_t r);
    int unsigned w, b, i, bo, bs, be;
    bit hit, mp, mn;
    w = addr / eff_wb();
    hit = 0;
    for (b = 0; b < blk_n; b++)
      if (w >= blk_off[b] && w < blk_off[b] + blk_len[b]) begin
        hit = 1;
        break;
      end
    if (!hit) begin
      r = mk(ST_NOTFOUND, 0, 0);
      return;
    end
    bo = blk_off[b];
    bs = blk_len[b];
    be = bo + bs;
    for (i = 0; i < hole_n && hole_off[i] <= bo; i++) ;
    mp = i > 0 && hole_off[i-1] + hole_len[i-1] == bo;
    mn = i < hole_n && hole_off[i] == be;
    if (!mp && !mn && hole_n >= NH) begin
      r = mk(ST_FULL, 0, 0);
      return;
    end
    blk_off[b] = blk_off[blk_n-1];
    blk_len[b] = blk_len[blk_n-1];
    blk_n--;
    if (mp && mn) begin
      hole_len[i-1] += bs + hole_len[i];
      for (; i + 1 < hole_n; i++) begin
        hole_off[i] = hole_off[i+1];
        hole_len[i] = hole_len[i+1];
      end
      hole_n--;
    end else if (mp) begin
      hole_len[i-1] += bs;
    end else if (mn) begin
      hole_off[i] = bo;
      hole_len[i] += bs;
    end else begin
      for (int k = hole_n; k > i; k--) begin
        hole_off[k] = hole_off[k-1];
        hole_len[k] = hole_len[k-1];
      end
      hole_off[i] = bo;
      hole_len[i] = bs;
      hole_n++;
    end
    r = mk(ST_OK, 0, bs);
  endtask

  assign pending = expected_results.size();

  always @(posedge clk) begin
    alloc_result_t r, got, exp_r;
    if (rst) begin
      mode_q <= FIT_BEST;
      wbytes_q = 4;
      region_q = 16'hFFFF;
      clear_heap();
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_FIT_MODE: mode_q <= cfg_wdata[0];
          REG_WORD_BYTES: wbytes_q = cfg_wdata[WB_W-1:0];
          REG_MEMORY_WORDS: begin
            region_q = cfg_wdata;
            clear_heap();
          end
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == CMD_ALLOC) predict_alloc(s_tdata[18:0], r);
        else predict_free(s_tdata[37:19], r);
        expected_results.push_back(r);
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[36:0];
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: %h", got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (got.status !== exp_r.status)
            $error("status: expected %0d got %0d", exp_r.status, got.status);
          if (got.offset !== exp_r.offset)
            $error("block_offset: expected %0d got %0d", exp_r.offset, got.offset);
          if (got.words !== exp_r.words)
            $error("block_words: expected %0d got %0d", exp_r.words, got.words);
          if (got !== exp_r) fail_count <= fail_count + 1;
        end
      end
    end
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import hlwa_pkg::*;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;   // size_bytes[18:0], byte_address[37:19], zero pad
  logic                   s_tuser;   // cmd
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // status[1:0], block_offset[20:2], block_words[36:21]
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_addr;
  logic [SIZE_W-1:0]      cfg_wdata;
  int                     fail_count;
  int                     pending;
  int                     quiet_cycles;

  // the slowest item plus long gaps; generous headroom
  localparam int WATCHDOG_LIMIT = 20000;

  hole_list_word_allocator_unit dut (.*);

  hlwa_checker chk (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // short gaps mostly, a long one now and then, and runs with none
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(3, 1);
    return $urandom_range(300, 20);
  endfunction

  // receiver stalls
  initial begin
    m_tready = 0;
    @(posedge clk iff !rst);
    forever begin
      m_tready <= 1;
      repeat ($urandom_range(20, 1)) @(posedge clk);
      repeat (gap_len()) begin
        m_tready <= 0;
        @(posedge clk);
      end
    end
  end

  // watchdog: no accepted beat on either side for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL hole_list_word_allocator_unit");
      $finish;
    end
  end

  // send one beat and wait for acceptance
  task automatic send_op(input logic cmd, input int unsigned val);
    int g;
    logic [IN_TDATA_W-1:0] d;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    // unused field gets noise
    d = '0;
    if (cmd == CMD_ALLOC) begin
      d[18:0]  = val[18:0];
      d[37:19] = BYTE_W'($urandom);
    end else begin
      d[37:19] = val[18:0];
      d[18:0]  = BYTE_W'($urandom);
    end
    s_tvalid <= 1;
    s_tuser  <= cmd;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // drain, then let the block settle before a register write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned v);
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    cfg_we    <= 1;
    cfg_addr  <= idx;
    cfg_wdata <= v[SIZE_W-1:0];
    @(posedge clk);
    cfg_we <= 0;
    repeat (3) @(posedge clk);
  endtask

  // mostly allocations and frees within a low address range, some noise
  task automatic random_phase(input int n, input int unsigned max_bytes);
    int unsigned live[$];
    int unsigned a, idx;
    for (int k = 0; k < n; k++) begin
      a = $urandom_range(99);
      if (a < 50) begin
        a = $urandom_range(max_bytes, 1);
        if ($urandom_range(19) == 0) a = $urandom_range(524287);
        send_op(CMD_ALLOC, a);
        live.push_back(a);
      end else if (a < 90 && live.size() > 0) begin
        // free somewhere inside a likely block start region
        idx = $urandom_range(live.size() - 1);
        send_op(CMD_FREE, $urandom_range(max_bytes * 8));
        live.delete(idx);
      end else begin
        send_op(CMD_FREE, $urandom_range(524287));
      end
    end
  endtask

  initial begin
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    s_tuser = CMD_ALLOC;
    cfg_we = 0;
    cfg_addr = REG_FIT_MODE;
    cfg_wdata = '0;
    quiet_cycles = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    repeat (2) @(posedge clk);

    // directed: extremes, zero size, oversize, unknown address
    send_op(CMD_ALLOC, 0);
    send_op(CMD_ALLOC, 524287);
    send_op(CMD_ALLOC, 262140);
    send_op(CMD_ALLOC, 1);
    send_op(CMD_ALLOC, 7);
    send_op(CMD_FREE, 524287);
    send_op(CMD_FREE, 262140);
    send_op(CMD_FREE, 262144);
    send_op(CMD_FREE, 0);
    send_op(CMD_FREE, 262140);
    write_reg(REG_MEMORY_WORDS, 1);
    send_op(CMD_ALLOC, 4);
    send_op(CMD_ALLOC, 1);
    send_op(CMD_FREE, 3);
    send_op(CMD_ALLOC, 5);
    write_reg(REG_MEMORY_WORDS, 0);
    send_op(CMD_ALLOC, 1);
    write_reg(REG_WORD_BYTES, 0);
    write_reg(REG_MEMORY_WORDS, 300);
    // fill the block table, then fragment for hole-table pressure
    for (int k = 0; k < 66; k++) send_op(CMD_ALLOC, 1 + (k % 3));
    for (int k = 0; k < 66; k += 2) send_op(CMD_FREE, k * 2);

    // several settings, extremes included
    write_reg(REG_FIT_MODE, 1);
    write_reg(REG_WORD_BYTES, 8);
    write_reg(REG_MEMORY_WORDS, 65535);
    random_phase(200, 600000);
    write_reg(REG_WORD_BYTES, 15);
    write_reg(REG_MEMORY_WORDS, 200);
    random_phase(200, 100);
    write_reg(REG_FIT_MODE, 0);
    write_reg(REG_WORD_BYTES, 1);
    write_reg(REG_MEMORY_WORDS, 120);
    random_phase(200, 12);
    write_reg(REG_WORD_BYTES, 3);
    write_reg(REG_MEMORY_WORDS, 1000);
    random_phase(200, 80);
    write_reg(REG_FIT_MODE, 1);
    write_reg(REG_WORD_BYTES, 4);
    write_reg(REG_MEMORY_WORDS, 40000);
    random_phase(150, 524280);

    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS hole_list_word_allocator_unit");
    end else begin
      $display("FAIL hole_list_word_allocator_unit");
    end
    $finish;
  end

endmodule
